/* rtl/grid_neighborhood_enumerator_macros.svh */
// ---------------------------------------------------------------------------
// grid neighbourhood enumerator assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef GRID_NEIGHBORHOOD_ENUMERATOR_MACROS_SVH
`define GRID_NEIGHBORHOOD_ENUMERATOR_MACROS_SVH

// property checked outside reset only
`define GNE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define GNE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gne_pkg.sv */
// ---------------------------------------------------------------------------
// gne_pkg
// shared constants, register indexes and types of the neighbourhood enumerator
// ---------------------------------------------------------------------------
package gne_pkg;

   // default parameter values
   localparam int MAX_RADIUS_DEF = 3;
   localparam int COORD_BITS_DEF = 10;

   // fixed field widths
   localparam int RADIUS_BITS    = 2;
   localparam int DIM_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // register reset values
   localparam logic [DIM_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
   localparam logic [DIM_BITS-1:0] GRID_HEIGHT_RST = 11'd1024;
   localparam logic                WRAP_RST        = 1'b0;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GRID_WIDTH    = 2'd0,
      REG_GRID_HEIGHT   = 2'd1,
      REG_WRAP_TOROIDAL = 2'd2
   } csr_reg_type;

   // word handed from the scan sequencer to the output register
   typedef struct packed {
      logic valid;
      logic last;
   } push_type;

endpackage

/* rtl/gne_if.sv */
// ---------------------------------------------------------------------------
// gne channel interfaces
// query, result and register write channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface gne_req_if #(
   parameter int COORD_BITS = gne_pkg::COORD_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic [COORD_BITS-1:0]            pos_x;
   logic [COORD_BITS-1:0]            pos_y;
   logic [gne_pkg::RADIUS_BITS-1:0]  radius;
   logic                             square_shape;
   logic                             include_center;

   modport source (
      output valid, pos_x, pos_y, radius, square_shape, include_center,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, radius, square_shape, include_center,
      output ready
   );
endinterface

interface gne_rsp_if #(
   parameter int COORD_BITS = gne_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] nb_x;
   logic [COORD_BITS-1:0] nb_y;
   logic                  last;

   modport source (
      output valid, nb_x, nb_y, last,
      input  ready
   );
   modport sink (
      input  valid, nb_x, nb_y, last,
      output ready
   );
endinterface

interface gne_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gne_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [gne_pkg::CSR_DATA_BITS-1:0]   wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );
   modport sink (
      input  valid, index, wdata,
      output ready
   );
endinterface

/* rtl/gne_remainder.sv */
// ---------------------------------------------------------------------------
// gne_remainder
// restoring remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
module gne_remainder #(
   parameter int NUM_BITS = gne_pkg::COORD_BITS_DEF,
   parameter int DEN_BITS = gne_pkg::DIM_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [DEN_BITS-1:0] rem
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;

   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   // one trial subtract per cycle
   always_comb begin
      trial = {rem_ff, num_ff[NUM_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/gne_scan.sv */
// ---------------------------------------------------------------------------
// gne_scan
// query sequencer: centre reduction, offset scan, torus fold and hold stage
// ---------------------------------------------------------------------------
module gne_scan #(
   parameter int MAX_RADIUS = gne_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = gne_pkg::COORD_BITS_DEF,
   parameter int DW         = gne_pkg::DIM_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   gne_req_if.sink               req_ch,
   input  logic                  wrap,
   input  logic [DW-1:0]         w_dim,
   input  logic [DW-1:0]         h_dim,
   input  logic                  out_free,
   output gne_pkg::push_type     push,
   output logic [COORD_BITS-1:0] push_x,
   output logic [COORD_BITS-1:0] push_y
);

   localparam int RB = $clog2(MAX_RADIUS + 1);
   localparam int OW = RB + 1;
   localparam int SW = DW + 2;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MODX  = 6'b000010,
      S_MODY  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_FOLD  = 6'b010000,
      S_FLUSH = 6'b100000
   } scan_state_type;

   scan_state_type        state_ff, state_in;
   logic [DW-1:0]         base_x_ff, base_x_in;
   logic [DW-1:0]         base_y_ff, base_y_in;
   logic [RB-1:0]         r_ff, r_in;
   logic                  sq_ff, sq_in;
   logic                  ctr_ff, ctr_in;
   logic signed [OW-1:0]  dx_ff, dx_in;
   logic signed [OW-1:0]  dy_ff, dy_in;
   logic signed [SW-1:0]  fx_ff, fx_in;
   logic signed [SW-1:0]  fy_ff, fy_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [COORD_BITS-1:0] pend_x_ff, pend_x_in;
   logic [COORD_BITS-1:0] pend_y_ff, pend_y_in;

   logic                  rem_start;
   logic [COORD_BITS-1:0] rem_dividend;
   logic [DW-1:0]         rem_divisor;
   logic                  rem_done;
   logic [DW-1:0]         rem_value;

   logic [RB-1:0]         r_sat;
   logic signed [OW-1:0]  neg_r_sat;
   logic signed [OW-1:0]  r_s;
   logic signed [OW-1:0]  neg_r;
   logic signed [OW-1:0]  adx_full, ady_full;
   logic [RB-1:0]         adx, ady;
   logic [RB:0]           manhattan;
   logic                  skip;
   logic                  last_offset;
   logic signed [SW-1:0]  w_s, h_s;
   logic signed [SW-1:0]  cand_x, cand_y;
   logic signed [SW-1:0]  cur_x, cur_y;
   logic signed [SW-1:0]  adj_x, adj_y;
   logic                  in_x, in_y;
   logic                  stall;
   logic                  take;
   logic                  advance;

   // shared remainder unit reduces the centre onto the torus
   gne_remainder #(
      .NUM_BITS (COORD_BITS),
      .DEN_BITS (DW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .done     (rem_done),
      .rem      (rem_value)
   );

   // radius saturation
   always_comb begin
      r_sat     = (int'(req_ch.radius) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(req_ch.radius);
      neg_r_sat = -$signed({1'b0, r_sat});
      r_s       = $signed({1'b0, r_ff});
      neg_r     = -r_s;
   end

   // shape and centre filter of the current offset
   always_comb begin
      adx_full    = dx_ff[OW-1] ? -dx_ff : dx_ff;
      ady_full    = dy_ff[OW-1] ? -dy_ff : dy_ff;
      adx         = adx_full[RB-1:0];
      ady         = ady_full[RB-1:0];
      manhattan   = {1'b0, adx} + {1'b0, ady};
      skip        = (!sq_ff && (manhattan > {1'b0, r_ff}))
                    || ((dx_ff == '0) && (dy_ff == '0) && !ctr_ff);
      last_offset = (dx_ff == r_s) && (dy_ff == r_s);
   end

   // coordinate unit: bounds compare and one fold step per axis
   always_comb begin
      w_s    = $signed({2'b00, w_dim});
      h_s    = $signed({2'b00, h_dim});
      cand_x = $signed({2'b00, base_x_ff}) + SW'(dx_ff);
      cand_y = $signed({2'b00, base_y_ff}) + SW'(dy_ff);
      cur_x  = (state_ff == S_FOLD) ? fx_ff : cand_x;
      cur_y  = (state_ff == S_FOLD) ? fy_ff : cand_y;
      in_x   = !cur_x[SW-1] && (cur_x < w_s);
      in_y   = !cur_y[SW-1] && (cur_y < h_s);
      adj_x  = cur_x[SW-1] ? cur_x + w_s : cur_x - w_s;
      adj_y  = cur_y[SW-1] ? cur_y + h_s : cur_y - h_s;
      stall  = pend_valid_ff && !out_free;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      base_x_in     = base_x_ff;
      base_y_in     = base_y_ff;
      r_in          = r_ff;
      sq_in         = sq_ff;
      ctr_in        = ctr_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      rem_start     = 1'b0;
      rem_dividend  = '0;
      rem_divisor   = '0;
      push          = '0;
      push_x        = pend_x_ff;
      push_y        = pend_y_ff;
      req_ch.ready  = 1'b0;
      take          = 1'b0;
      advance       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               base_x_in = DW'(req_ch.pos_x);
               base_y_in = DW'(req_ch.pos_y);
               r_in      = r_sat;
               sq_in     = req_ch.square_shape;
               ctr_in    = req_ch.include_center;
               dx_in     = neg_r_sat;
               dy_in     = neg_r_sat;
               if (wrap) begin
                  rem_start    = 1'b1;
                  rem_dividend = req_ch.pos_x;
                  rem_divisor  = w_dim;
                  state_in     = S_MODX;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_MODX: begin
            if (rem_done) begin
               base_x_in    = rem_value;
               rem_start    = 1'b1;
               rem_dividend = base_y_ff[COORD_BITS-1:0];
               rem_divisor  = h_dim;
               state_in     = S_MODY;
            end
         end
         S_MODY: begin
            if (rem_done) begin
               base_y_in = rem_value;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (skip) begin
               advance = 1'b1;
            end else if (in_x && in_y) begin
               take = !stall;
            end else if (wrap) begin
               fx_in    = in_x ? cur_x : adj_x;
               fy_in    = in_y ? cur_y : adj_y;
               state_in = S_FOLD;
            end else begin
               advance = 1'b1;
            end
         end
         S_FOLD: begin
            if (in_x && in_y) begin
               take = !stall;
            end else begin
               fx_in = in_x ? cur_x : adj_x;
               fy_in = in_y ? cur_y : adj_y;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push.valid    = 1'b1;
               push.last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // new neighbour enters the hold stage, the previous one moves on
      if (take) begin
         pend_valid_in = 1'b1;
         pend_x_in     = cur_x[COORD_BITS-1:0];
         pend_y_in     = cur_y[COORD_BITS-1:0];
         push.valid    = pend_valid_ff;
         advance       = 1'b1;
      end

      // row-major offset step
      if (advance) begin
         if (last_offset) begin
            state_in = S_FLUSH;
         end else begin
            state_in = S_SCAN;
            if (dx_ff == r_s) begin
               dx_in = neg_r;
               dy_in = dy_ff + OW'(1);
            end else begin
               dx_in = dx_ff + OW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_x_ff <= base_x_in;
      base_y_ff <= base_y_in;
      r_ff      <= r_in;
      sq_ff     <= sq_in;
      ctr_ff    <= ctr_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
   end

endmodule

/* rtl/grid_neighborhood_enumerator.sv */
// ---------------------------------------------------------------------------
// grid_neighborhood_enumerator
// lists the neighbour cells of one grid position, square or diamond shape
// ---------------------------------------------------------------------------
// channels: req_ch takes one query word (centre, radius, shape, centre flag);
// rsp_ch returns one word per neighbour in row-major order, dy outer, dx inner,
// with last set on the final word; csr_ch writes grid_width, grid_height and
// wrap_toroidal, and is always ready.
// rate: the scan visits one offset per cycle while no stall holds it, then a
// flush state and an idle state that takes the next query. With wrap on, the
// shared remainder unit first reduces the centre, x and then y, and each
// neighbour that lands off the grid is folded one step per axis at a time in
// a fold state; without wrap it is dropped.
// hold: a neighbour waits in a one-word hold stage until the next is found
// or the scan ends, so that last can be marked; the flush state passes the last
// word on to the output register. req_ch is ready only between queries.
// stall: when the hold stage has a word to pass on and the output register is
// still full, the scan holds at its next neighbour until rsp_ch takes the word.
// reset: registers go to 1024 x 1024 without wrap, the output register empties
// and the block is ready for a query on the next cycle.
// ---------------------------------------------------------------------------
module grid_neighborhood_enumerator #(
   parameter int MAX_RADIUS = gne_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = gne_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gne_req_if.sink   req_ch,
   gne_rsp_if.source rsp_ch,
   gne_csr_if.sink   csr_ch
);

   localparam int DW = (COORD_BITS + 1 > gne_pkg::DIM_BITS) ? COORD_BITS + 1
                                                            : gne_pkg::DIM_BITS;
   localparam logic [DW-1:0] DIM_MAX = DW'(1) << COORD_BITS;

   logic [gne_pkg::DIM_BITS-1:0] grid_width_ff, grid_width_in;
   logic [gne_pkg::DIM_BITS-1:0] grid_height_ff, grid_height_in;
   logic                         wrap_ff, wrap_in;

   logic [DW-1:0]                w_dim, h_dim;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]        nb_x_ff, nb_x_in;
   logic [COORD_BITS-1:0]        nb_y_ff, nb_y_in;
   logic                         last_ff, last_in;

   logic                         out_free;
   gne_pkg::push_type            push;
   logic [COORD_BITS-1:0]        push_x, push_y;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      wrap_in        = wrap_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            gne_pkg::REG_GRID_WIDTH: begin
               grid_width_in = csr_ch.wdata[gne_pkg::DIM_BITS-1:0];
            end
            gne_pkg::REG_GRID_HEIGHT: begin
               grid_height_in = csr_ch.wdata[gne_pkg::DIM_BITS-1:0];
            end
            gne_pkg::REG_WRAP_TOROIDAL: begin
               wrap_in = csr_ch.wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gne_pkg::GRID_WIDTH_RST;
         grid_height_ff <= gne_pkg::GRID_HEIGHT_RST;
         wrap_ff        <= gne_pkg::WRAP_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         wrap_ff        <= wrap_in;
      end
   end

   // empty grid acts as one cell, oversized grid is capped at the coordinate range
   always_comb begin
      w_dim = DW'(grid_width_ff);
      if (grid_width_ff == '0) begin
         w_dim = DW'(1);
      end else if (DW'(grid_width_ff) > DIM_MAX) begin
         w_dim = DIM_MAX;
      end
      h_dim = DW'(grid_height_ff);
      if (grid_height_ff == '0) begin
         h_dim = DW'(1);
      end else if (DW'(grid_height_ff) > DIM_MAX) begin
         h_dim = DIM_MAX;
      end
   end

   gne_scan #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS),
      .DW         (DW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .wrap     (wrap_ff),
      .w_dim    (w_dim),
      .h_dim    (h_dim),
      .out_free (out_free),
      .push     (push),
      .push_x   (push_x),
      .push_y   (push_y)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      nb_x_in      = nb_x_ff;
      nb_y_in      = nb_y_ff;
      last_in      = last_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         nb_x_in      = push_x;
         nb_y_in      = push_y;
         last_in      = push.last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_x_ff <= nb_x_in;
      nb_y_ff <= nb_y_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.nb_x  = nb_x_ff;
   assign rsp_ch.nb_y  = nb_y_ff;
   assign rsp_ch.last  = last_ff;

endmodule

/* rtl/gne_checker.sv */
// ---------------------------------------------------------------------------
// gne_checker
// port-level checks of the neighbourhood enumerator, bound to the top level
// ---------------------------------------------------------------------------
`include "grid_neighborhood_enumerator_macros.svh"

module gne_checker #(
   parameter int COORD_BITS = gne_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_nb_x,
   input logic [COORD_BITS-1:0] rsp_nb_y,
   input logic                  rsp_last
);

   // reset leaves an empty output and an idle scan
   `GNE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "not idle after reset")

   // a stalled result word holds
   `GNE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_nb_x) && $stable(rsp_nb_y) && $stable(rsp_last)), "result word changed under stall")

   // a query in progress blocks the next one
   `GNE_ASSERT(a_accept_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready right after a query was taken")

   // words before the last one belong to a query still being scanned
   `GNE_ASSERT(a_mid_busy, clock, reset, (rsp_valid && !rsp_last) |-> !req_ready, "ready while a query is unfinished")

endmodule

bind grid_neighborhood_enumerator gne_checker #(
   .COORD_BITS (COORD_BITS)
) u_gne_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_nb_x  (rsp_ch.nb_x),
   .rsp_nb_y  (rsp_ch.nb_y),
   .rsp_last  (rsp_ch.last)
);

/* tb/sv/neighbour_list_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// neighbour list checker
// watches the query, result and register channels of the neighbourhood
// enumerator, works out the neighbour words each query should produce and
// compares every result word against the oldest one still outstanding
// ---------------------------------------------------------------------------
module neighbour_list_checker (
   input  logic clock,
   input  logic reset,
   gne_req_if   req_ch,
   gne_rsp_if   rsp_ch,
   gne_csr_if   csr_ch,
   output int   fail_count,
   output int   words_pending
);

   localparam int COORD_BITS = gne_pkg::COORD_BITS_DEF;
   localparam int DIM_LIMIT  = 1 << COORD_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] nb_x;
      logic [COORD_BITS-1:0] nb_y;
      logic                  last;
   } neighbour_word_type;

   // shadow copy of the register file
   logic [gne_pkg::DIM_BITS-1:0] grid_width    = gne_pkg::GRID_WIDTH_RST;
   logic [gne_pkg::DIM_BITS-1:0] grid_height   = gne_pkg::GRID_HEIGHT_RST;
   logic                         wrap_toroidal = gne_pkg::WRAP_RST;

   int mismatches  = 0;
   int outstanding = 0;

   neighbour_word_type expected_words[$];

   assign fail_count    = mismatches;
   assign words_pending = outstanding;

   // zero acts as one, anything past the coordinate range saturates
   function automatic int effective_dim(input logic [gne_pkg::DIM_BITS-1:0] dim);
      if (dim == 0) return 1;
      if (dim > DIM_LIMIT) return DIM_LIMIT;
      return int'(dim);
   endfunction

   // scan dy outer, dx inner; drop or fold off-grid cells, mark the final word
   function automatic void predict_neighbours(
      input logic [COORD_BITS-1:0]           px,
      input logic [COORD_BITS-1:0]           py,
      input logic [gne_pkg::RADIUS_BITS-1:0] radius,
      input logic                            square_shape,
      input logic                            include_center
   );
      int                 w, h, r, dx, dy, nx, ny, ax, ay;
      neighbour_word_type word;
      neighbour_word_type found[$];
      w = effective_dim(grid_width);
      h = effective_dim(grid_height);
      r = int'(radius);
      if (r > gne_pkg::MAX_RADIUS_DEF) r = gne_pkg::MAX_RADIUS_DEF;
      for (dy = -r; dy <= r; dy++) begin
         for (dx = -r; dx <= r; dx++) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            nx = int'(px) + dx;
            ny = int'(py) + dy;
            if (!square_shape && (ax + ay > r)) continue;
            if (dx == 0 && dy == 0 && !include_center) continue;
            if (nx < 0 || nx >= w || ny < 0 || ny >= h) begin
               if (!wrap_toroidal) continue;
               nx = ((nx % w) + w) % w;
               ny = ((ny % h) + h) % h;
            end
            word.nb_x = nx[COORD_BITS-1:0];
            word.nb_y = ny[COORD_BITS-1:0];
            word.last = 1'b0;
            found.insert(found.size(), word);
         end
      end
      foreach (found[i]) begin
         word      = found[i];
         word.last = (i == found.size() - 1);
         expected_words.insert(expected_words.size(), word);
      end
   endfunction

   // sample all three channels on the rising edge
   always @(posedge clock) begin : monitor
      neighbour_word_type want;
      if (reset) begin
         grid_width    = gne_pkg::GRID_WIDTH_RST;
         grid_height   = gne_pkg::GRID_HEIGHT_RST;
         wrap_toroidal = gne_pkg::WRAP_RST;
         expected_words.delete();
      end else begin
         // register writes
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               gne_pkg::REG_GRID_WIDTH:    grid_width    = csr_ch.wdata;
               gne_pkg::REG_GRID_HEIGHT:   grid_height   = csr_ch.wdata;
               gne_pkg::REG_WRAP_TOROIDAL: wrap_toroidal = csr_ch.wdata[0];
               default: ;
            endcase
         end
         // accepted query
         if (req_ch.valid && req_ch.ready)
            predict_neighbours(req_ch.pos_x, req_ch.pos_y, req_ch.radius,
                               req_ch.square_shape, req_ch.include_center);
         // accepted result word
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: nb_x %0d nb_y %0d last %0b",
                      rsp_ch.nb_x, rsp_ch.nb_y, rsp_ch.last);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.nb_x !== want.nb_x) begin
                  $error("nb_x mismatch: expected %0d, actual %0d", want.nb_x, rsp_ch.nb_x);
                  mismatches++;
               end
               if (rsp_ch.nb_y !== want.nb_y) begin
                  $error("nb_y mismatch: expected %0d, actual %0d", want.nb_y, rsp_ch.nb_y);
                  mismatches++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_ch.last);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_words.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// grid neighbourhood enumerator testbench
// drives directed and random neighbourhood queries across several grid
// settings, with random stalls on both channels; the checker predicts the
// neighbour words and counts mismatches, this top gives the verdict
// ---------------------------------------------------------------------------
module testbench;

   localparam int COORD_BITS    = gne_pkg::COORD_BITS_DEF;
   localparam int DIM_BITS      = gne_pkg::DIM_BITS;
   localparam int RADIUS_BITS   = gne_pkg::RADIUS_BITS;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_QUERIES = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   words_pending;
   int   cycle_count = 0;
   bit   calm_run = 1'b0;
   int   stall_left = 0;

   gne_req_if req_ch ();
   gne_rsp_if rsp_ch ();
   gne_csr_if csr_ch ();

   always #5 clock = ~clock;

   grid_neighborhood_enumerator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   neighbour_list_checker u_neighbour_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // result back-pressure in random bursts, none once the run goes calm
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (calm_run) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // one query word, after an optional random gap
   task automatic send_query(
      input logic [COORD_BITS-1:0]  px,
      input logic [COORD_BITS-1:0]  py,
      input logic [RADIUS_BITS-1:0] radius,
      input logic                   square_shape,
      input logic                   include_center
   );
      int gap;
      if (!calm_run && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.pos_x          <= px;
      req_ch.pos_y          <= py;
      req_ch.radius         <= radius;
      req_ch.square_shape   <= square_shape;
      req_ch.include_center <= include_center;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(input gne_pkg::csr_reg_type index,
                            input logic [DIM_BITS-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // hold off queries until every word is back and the scan has wound down
   task automatic settle_block;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_grid(
      input logic [DIM_BITS-1:0] width,
      input logic [DIM_BITS-1:0] height,
      input logic                wrap
   );
      write_reg(gne_pkg::REG_GRID_WIDTH, width);
      write_reg(gne_pkg::REG_GRID_HEIGHT, height);
      write_reg(gne_pkg::REG_WRAP_TOROIDAL, {{(DIM_BITS-1){1'b0}}, wrap});
   endtask

   // grid sizes from degenerate to oversized
   function automatic logic [DIM_BITS-1:0] pick_dim();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return DIM_BITS'($urandom_range(1, 4));
         2:       return DIM_BITS'($urandom_range(5, 16));
         3:       return DIM_BITS'($urandom_range(17, 1024));
         4:       return DIM_BITS'($urandom_range(1025, 2047));
         default: return DIM_BITS'(1024);
      endcase
   endfunction

   // mostly inside the grid, sometimes on its edges, sometimes anywhere
   function automatic logic [COORD_BITS-1:0] pick_pos(input logic [DIM_BITS-1:0] dim);
      int span;
      span = (dim == 0) ? 1 : ((dim > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(dim));
      case ($urandom_range(0, 7))
         0:       return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
         1:       return '0;
         2:       return COORD_BITS'(span - 1);
         default: return COORD_BITS'($urandom_range(0, span - 1));
      endcase
   endfunction

   initial begin : stimulus
      logic [DIM_BITS-1:0] width, height;
      req_ch.valid          = 1'b0;
      req_ch.pos_x          = '0;
      req_ch.pos_y          = '0;
      req_ch.radius         = '0;
      req_ch.square_shape   = 1'b0;
      req_ch.include_center = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = gne_pkg::REG_GRID_WIDTH;
      csr_ch.wdata          = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset grid, drop mode: corners, full diamond, empty and lone centre
      send_query(10'd0,   10'd0,   2'd3, 1'b1, 1'b1);
      send_query(10'h3FF, 10'h3FF, 2'd3, 1'b1, 1'b0);
      send_query(10'd512, 10'd512, 2'd3, 1'b0, 1'b1);
      send_query(10'd512, 10'd512, 2'd0, 1'b1, 1'b0);
      send_query(10'd512, 10'd512, 2'd0, 1'b0, 1'b1);
      send_query(10'd5,   10'd1020, 2'd2, 1'b1, 1'b1);
      send_query(10'h3FF, 10'd0,   2'd1, 1'b0, 1'b0);
      send_query(10'd0,   10'h3FF, 2'd1, 1'b1, 1'b1);
      settle_block();

      // small torus: duplicates, centre off the grid gets folded
      set_grid(11'd5, 11'd3, 1'b1);
      send_query(10'd0,   10'd0,   2'd3, 1'b1, 1'b1);
      send_query(10'h3FF, 10'h3FF, 2'd3, 1'b1, 1'b0);
      send_query(10'd2,   10'd1,   2'd2, 1'b0, 1'b1);
      send_query(10'd4,   10'd2,   2'd1, 1'b1, 1'b0);
      settle_block();

      // zero-sized grid behaves as one cell
      set_grid(11'd0, 11'd0, 1'b1);
      send_query(10'd0, 10'd0, 2'd3, 1'b1, 1'b1);
      send_query(10'd7, 10'd9, 2'd1, 1'b0, 1'b0);
      settle_block();

      // oversized grid saturates to the coordinate range
      set_grid(11'd2047, 11'd1500, 1'b1);
      send_query(10'd0,   10'd0,   2'd3, 1'b1, 1'b1);
      send_query(10'h3FF, 10'h3FF, 2'd2, 1'b0, 1'b1);
      settle_block();

      // single cell without wrap: centre off the grid drops everything
      set_grid(11'd1, 11'd1, 1'b0);
      send_query(10'd3, 10'd3, 2'd1, 1'b1, 1'b1);
      send_query(10'd0, 10'd0, 2'd3, 1'b1, 1'b1);
      settle_block();

      // random grids and queries, the last phase with no stalls at all
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         width  = pick_dim();
         height = pick_dim();
         set_grid(width, height, 1'($urandom_range(0, 1)));
         if (phase == RANDOM_PHASES - 1) calm_run = 1'b1;
         for (int n = 0; n < PHASE_QUERIES; n++)
            send_query(pick_pos(width), pick_pos(height),
                       RADIUS_BITS'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         settle_block();
      end

      if (fail_count == 0 && words_pending == 0) begin
         $display("SUCCESS");
      end else begin
         if (words_pending != 0)
            $error("%0d expected neighbour words never arrived", words_pending);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gne_pkg.sv
rtl/gne_if.sv
rtl/gne_remainder.sv
rtl/gne_scan.sv
rtl/grid_neighborhood_enumerator.sv
rtl/gne_checker.sv
tb/sv/neighbour_list_checker.sv
tb/sv/testbench.sv
